@@ rtl/bdeq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bdeq_pkg;

    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;
    localparam int OUT_W     = 32;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Result of one operation, minus the popped data that arrives from the RAM.
    typedef struct packed {
        status_t            status;
        logic               popped;
        logic [CAP_W-1:0]   count;
        logic               is_empty;
        logic               is_full;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/bdeq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, registered read.
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/bounded_double_ended_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: push_value[31:0]; tuser: mode[1:0]
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: pop_value[31:0], entry_count[36:32],
//                                               is_empty[37], is_full[38], zero[39];
//                                               tuser: status[1:0]
// cfg       in   cfg_we (no wait)               cfg_wdata: capacity[4:0]
//
// One word per cycle sustained while m_axis is not stalled. Pointers and
// occupancy sit in flops and update at accept; the entry RAM is written at
// accept or read at accept, with registered read data. A word taken passes
// through a stage and then an output register to m_axis; the two decouple
// the sides: input stalls only if both hold a word and the output is stalled.
// Reset clears pointers, occupancy and valids, sets capacity to 16; RAM kept.
module bounded_double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      s_axis_tvalid,
    output      logic                      s_axis_tready,
    input  wire logic [31:0]               s_axis_tdata,  // push_value[31:0]
    input  wire logic [1:0]                s_axis_tuser,  // mode[1:0]

    output      logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output      logic [39:0]               m_axis_tdata,  // pop_value, entry_count, is_empty, is_full
    output      logic [1:0]                m_axis_tuser,  // status[1:0]

    input  wire logic                      cfg_we,
    input  wire logic [bdeq_pkg::CAP_W-1:0] cfg_wdata     // capacity[4:0]
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = bdeq_pkg::CAP_W;

    // ---------------- control state ----------------
    logic [CW-1:0]  capacity_reg;
    logic [PW-1:0]  front_reg, front_next;
    logic [PW-1:0]  back_reg, back_next;
    logic [CW-1:0]  occ_reg, occ_next;

    logic           stg_valid_reg;
    bdeq_pkg::res_t stg_res_reg, stg_res_next;

    logic           out_valid_reg;
    bdeq_pkg::res_t out_res_reg;
    logic [31:0]    out_data_reg;

    // ---------------- RAM port signals ----------------
    logic                  ram_we;
    logic [PW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [PW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  in_acc;
    logic                  out_load;
    logic [CW-1:0]         eff_cap;
    logic [63:0]           push_wide;
    logic signed [63:0]    pop_ext;
    logic [31:0]           pop_word;
    bdeq_pkg::mode_t       mode;
    bdeq_pkg::status_t     st;
    logic                  popped;

    function automatic logic [PW-1:0] step_up(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] step_down(input logic [PW-1:0] p);
        return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
    endfunction

    // Capacity saturates at the RAM depth.
    assign eff_cap = (32'(capacity_reg) > DEPTH) ? CW'(DEPTH) : capacity_reg;

    // Stage drains into the output register when that is empty or being taken.
    assign out_load      = stg_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !stg_valid_reg || out_load;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign mode      = bdeq_pkg::mode_t'(s_axis_tuser);
    assign push_wide = {32'b0, s_axis_tdata};
    assign ram_wdata = push_wide[DATA_WIDTH-1:0];

    // Decode the operation against the current pointers.
    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        occ_next   = occ_reg;
        ram_we     = 1'b0;
        ram_waddr  = back_reg;
        ram_re     = 1'b0;
        ram_raddr  = front_reg;
        st         = bdeq_pkg::ST_DONE;
        popped     = 1'b0;
        case (mode)
            bdeq_pkg::MODE_PUSH_FRONT:
            begin
                if (occ_reg >= eff_cap)
                begin
                    st = bdeq_pkg::ST_FULL;
                end
                else
                begin
                    front_next = step_down(front_reg);
                    ram_we     = in_acc;
                    ram_waddr  = step_down(front_reg);
                    occ_next   = occ_reg + CW'(1);
                end
            end
            bdeq_pkg::MODE_PUSH_BACK:
            begin
                if (occ_reg >= eff_cap)
                begin
                    st = bdeq_pkg::ST_FULL;
                end
                else
                begin
                    back_next = step_up(back_reg);
                    ram_we    = in_acc;
                    ram_waddr = back_reg;
                    occ_next  = occ_reg + CW'(1);
                end
            end
            bdeq_pkg::MODE_POP_FRONT:
            begin
                if (occ_reg == '0)
                begin
                    st = bdeq_pkg::ST_EMPTY;
                end
                else
                begin
                    front_next = step_up(front_reg);
                    ram_re     = in_acc;
                    ram_raddr  = front_reg;
                    popped     = 1'b1;
                    occ_next   = occ_reg - CW'(1);
                end
            end
            bdeq_pkg::MODE_POP_BACK:
            begin
                if (occ_reg == '0)
                begin
                    st = bdeq_pkg::ST_EMPTY;
                end
                else
                begin
                    back_next = step_down(back_reg);
                    ram_re    = in_acc;
                    ram_raddr = step_down(back_reg);
                    popped    = 1'b1;
                    occ_next  = occ_reg - CW'(1);
                end
            end
            default:
            begin
                st = bdeq_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        stg_res_next.status   = st;
        stg_res_next.popped   = popped;
        stg_res_next.count    = occ_next;
        stg_res_next.is_empty = (occ_next == '0);
        stg_res_next.is_full  = (occ_next >= eff_cap);
    end

    bdeq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sign-extend the stored word; rejected pops and pushes give all ones.
    assign pop_ext  = 64'(signed'(ram_rdata));
    assign pop_word = stg_res_reg.popped ? pop_ext[31:0] : '1;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CW'(bdeq_pkg::CAP_RESET);
            front_reg     <= '0;
            back_reg      <= '0;
            occ_reg       <= '0;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (in_acc)
            begin
                front_reg <= front_next;
                back_reg  <= back_next;
                occ_reg   <= occ_next;
            end
            if (s_axis_tready)
            begin
                stg_valid_reg <= s_axis_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            stg_res_reg <= stg_res_next;
        end
        if (out_load)
        begin
            out_res_reg  <= stg_res_reg;
            out_data_reg <= pop_word;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_res_reg.is_full, out_res_reg.is_empty,
                            out_res_reg.count, out_data_reg};
    assign m_axis_tuser  = out_res_reg.status;

endmodule

`default_nettype wire

@@ tb/sv/tb_bounded_double_ended_queue.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the bounded deque. A mirror of the ring buffer
// (pointers, occupancy, capacity) predicts one result word per accepted
// input word; results are compared field by field, in order, as they leave.
module tb_bounded_double_ended_queue;

    localparam int          DEPTH         = 16;
    localparam int          CLK_HALF_NS   = 5;
    localparam int          RESET_CYCLES  = 5;
    localparam int          SETTLE_CYCLES = 4;      // pipeline is two deep; margin on top
    localparam int          HOLD_CYCLES   = 60;     // long receiver hold-off
    localparam int          BLOCK_WORDS   = 155;    // random words per block
    localparam int          DRAIN_LIMIT   = 20000;
    localparam longint      TIMEOUT_NS    = 3_000_000;
    localparam logic [31:0] POP_NONE      = 32'hFFFF_FFFF;

    // Capacity per random block; -1 picks a random value over the whole field.
    localparam int CAP_PLAN [12] = '{16, 1, 0, 31, 16, -1, 2, 17, -1, 15, 16, -1};

    // One result word, unpacked from tdata/tuser.
    typedef struct packed {
        logic [31:0]       value;
        bdeq_pkg::status_t status;
        logic [4:0]        count;
        logic              empty;
        logic              full;
    } deq_result_t;

    // One row of the directed table: a capacity write or an operation, with
    // an optional hand-typed expectation.
    typedef struct packed {
        bit              is_cfg;
        logic [4:0]      cap;
        bdeq_pkg::mode_t op;
        logic [31:0]     data;
        bit              typed;
        deq_result_t     want;
    } plan_row_t;

    // ---------------------------------------------------------------- DUT ports
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // push_value[31:0]
    logic [1:0]  s_axis_tuser  = '0;    // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // pop_value[31:0], entry_count[36:32],
                                        // is_empty[37], is_full[38], zero[39]
    logic [1:0]  m_axis_tuser;          // status[1:0]
    logic        cfg_we        = 1'b0;
    logic [4:0]  cfg_wdata     = '0;    // capacity[4:0]

    // ------------------------------------------------------------ bench state
    int          send_idle_pct  = 0;    // chance per cycle the sender sits out
    int          recv_stall_pct = 0;    // chance per cycle the receiver stalls
    bit          hold_request   = 1'b0; // asks the receiver for a long hold-off
    int          mismatch_count = 0;
    int          words_seen     = 0;

    deq_result_t pending_results[$];    // predicted words, oldest first
    plan_row_t   directed_plan[$];

    // Mirror of the ring buffer. Pointers are 4 bits so they wrap at DEPTH.
    logic [31:0] mirror_store [DEPTH];
    logic [3:0]  mirror_front = '0;
    logic [3:0]  mirror_back  = '0;
    logic [4:0]  mirror_occ   = '0;
    logic [4:0]  mirror_cap   = 5'(bdeq_pkg::CAP_RESET);

    bounded_double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // Apply one operation to the mirror and return the word it must produce.
    // Capacities above DEPTH saturate; a capacity below the occupancy keeps
    // every entry and simply reports full.
    function automatic deq_result_t deque_apply(bdeq_pkg::mode_t op, logic [31:0] v);
        deq_result_t r;
        logic [4:0]  lim;
        lim      = (mirror_cap > 5'(DEPTH)) ? 5'(DEPTH) : mirror_cap;
        r.value  = POP_NONE;
        r.status = bdeq_pkg::ST_DONE;
        if (op == bdeq_pkg::MODE_PUSH_FRONT || op == bdeq_pkg::MODE_PUSH_BACK)
        begin
            if (mirror_occ >= lim)
                r.status = bdeq_pkg::ST_FULL;
            else if (op == bdeq_pkg::MODE_PUSH_FRONT)
            begin
                mirror_front               = mirror_front - 4'd1;
                mirror_store[mirror_front] = v;
                mirror_occ                 = mirror_occ + 5'd1;
            end
            else
            begin
                mirror_store[mirror_back] = v;
                mirror_back               = mirror_back + 4'd1;
                mirror_occ                = mirror_occ + 5'd1;
            end
        end
        else
        begin
            if (mirror_occ == 5'd0)
                r.status = bdeq_pkg::ST_EMPTY;
            else if (op == bdeq_pkg::MODE_POP_FRONT)
            begin
                r.value      = mirror_store[mirror_front];
                mirror_front = mirror_front + 4'd1;
                mirror_occ   = mirror_occ - 5'd1;
            end
            else
            begin
                mirror_back = mirror_back - 4'd1;
                r.value     = mirror_store[mirror_back];
                mirror_occ  = mirror_occ - 5'd1;
            end
        end
        r.count = mirror_occ;
        r.empty = (mirror_occ == 5'd0);
        r.full  = (mirror_occ >= lim);
        return r;
    endfunction

    // ------------------------------------------------------ directed rows
    function automatic plan_row_t row_cfg(logic [4:0] c);
        plan_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.cap    = c;
        row.op     = bdeq_pkg::MODE_PUSH_FRONT;
        return row;
    endfunction

    function automatic plan_row_t row_op(bdeq_pkg::mode_t op, logic [31:0] d);
        plan_row_t row;
        row      = '0;
        row.op   = op;
        row.data = d;
        return row;
    endfunction

    function automatic plan_row_t row_chk(bdeq_pkg::mode_t op, logic [31:0] d,
                                          logic [31:0] pv, bdeq_pkg::status_t st,
                                          logic [4:0] cnt, bit emp, bit ful);
        plan_row_t row;
        row             = row_op(op, d);
        row.typed       = 1'b1;
        row.want.value  = pv;
        row.want.status = st;
        row.want.count  = cnt;
        row.want.empty  = emp;
        row.want.full   = ful;
        return row;
    endfunction

    // One line per mismatch.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("mismatch on word %0d: %0s got %h want %h", words_seen, what, got, want);
    endtask

    // Offer one word; the mirror advances at the edge where it is taken.
    // tvalid stays high from one word to the next unless a gap is drawn.
    task automatic offer_word(bdeq_pkg::mode_t op, logic [31:0] v, bit typed,
                              deq_result_t want);
        deq_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= v;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = deque_apply(op, v);
        pending_results.push_back(typed ? want : r);
    endtask

    // Capacity is only written with the pipeline empty.
    task automatic set_capacity(logic [4:0] c);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we     <= 1'b0;
        mirror_cap  = c;
    endtask

    // Random payload, leaning now and then on the sign and magnitude extremes.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------- receiver side
    // Random stalls at the current rate; on request a long hold-off counted
    // here, during which the sender keeps offering and the block backs up.
    initial
    begin
        int hold_left;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------- checker
    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_seen++;
            if (pending_results.size() == 0)
                report_mismatch("word with nothing expected", m_axis_tdata[31:0], POP_NONE);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.value)
                    report_mismatch("pop_value", m_axis_tdata[31:0], want.value);
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[36:32] !== want.count)
                    report_mismatch("entry_count", 32'(m_axis_tdata[36:32]), 32'(want.count));
                if (m_axis_tdata[37] !== want.empty)
                    report_mismatch("is_empty", 32'(m_axis_tdata[37]), 32'(want.empty));
                if (m_axis_tdata[38] !== want.full)
                    report_mismatch("is_full", 32'(m_axis_tdata[38]), 32'(want.full));
            end
        end
    end

    // ---------------------------------------------------------- stimulus
    initial
    begin
        int              blk;
        int              k;
        int              push_bias;
        int              drain_wait;
        bdeq_pkg::mode_t op;
        logic [4:0]      cap_val;

        foreach (mirror_store[i])
            mirror_store[i] = '0;

        // Directed: empty pops, extremes at both ends, capacity zero and one,
        // an oversized capacity, and a capacity dropped below the occupancy.
        directed_plan = '{
            row_chk(bdeq_pkg::MODE_POP_FRONT,  32'h0000_0000, POP_NONE,
                    bdeq_pkg::ST_EMPTY, 5'd0, 1'b1, 1'b0),
            row_chk(bdeq_pkg::MODE_POP_BACK,   32'hDEAD_BEEF, POP_NONE,
                    bdeq_pkg::ST_EMPTY, 5'd0, 1'b1, 1'b0),
            row_chk(bdeq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF, POP_NONE,
                    bdeq_pkg::ST_DONE,  5'd1, 1'b0, 1'b0),
            row_chk(bdeq_pkg::MODE_PUSH_BACK,  32'h8000_0000, POP_NONE,
                    bdeq_pkg::ST_DONE,  5'd2, 1'b0, 1'b0),
            row_op (bdeq_pkg::MODE_PUSH_FRONT, 32'h0000_0000),
            row_op (bdeq_pkg::MODE_PUSH_BACK,  32'hFFFF_FFFF),
            row_op (bdeq_pkg::MODE_POP_FRONT,  32'h0000_0000),
            row_op (bdeq_pkg::MODE_POP_BACK,   32'h0000_0000),
            row_op (bdeq_pkg::MODE_POP_FRONT,  32'h0000_0000),
            row_op (bdeq_pkg::MODE_POP_BACK,   32'h0000_0000),
            row_cfg(5'd0),
            // zero capacity: always full, even while empty
            row_chk(bdeq_pkg::MODE_PUSH_FRONT, 32'h1234_5678, POP_NONE,
                    bdeq_pkg::ST_FULL,  5'd0, 1'b1, 1'b1),
            row_chk(bdeq_pkg::MODE_POP_BACK,   32'h0000_0000, POP_NONE,
                    bdeq_pkg::ST_EMPTY, 5'd0, 1'b1, 1'b1),
            row_cfg(5'd1),
            row_chk(bdeq_pkg::MODE_PUSH_BACK,  32'hA5A5_A5A5, POP_NONE,
                    bdeq_pkg::ST_DONE,  5'd1, 1'b0, 1'b1),
            row_chk(bdeq_pkg::MODE_PUSH_FRONT, 32'h5A5A_5A5A, POP_NONE,
                    bdeq_pkg::ST_FULL,  5'd1, 1'b0, 1'b1),
            row_cfg(5'd31),                             // saturates at DEPTH
            row_op (bdeq_pkg::MODE_PUSH_BACK,  32'h0000_0001),
            row_op (bdeq_pkg::MODE_PUSH_FRONT, 32'h0000_0002),
            row_op (bdeq_pkg::MODE_PUSH_BACK,  32'h0000_0003),
            row_cfg(5'd2),                              // below occupancy of 4
            row_chk(bdeq_pkg::MODE_PUSH_FRONT, 32'h0000_0009, POP_NONE,
                    bdeq_pkg::ST_FULL,  5'd4, 1'b0, 1'b1),
            row_op (bdeq_pkg::MODE_POP_FRONT,  32'h0000_0000),
            row_op (bdeq_pkg::MODE_POP_BACK,   32'h0000_0000),
            row_op (bdeq_pkg::MODE_POP_FRONT,  32'h0000_0000),
            row_op (bdeq_pkg::MODE_PUSH_BACK,  32'h0000_0005),
            row_op (bdeq_pkg::MODE_POP_BACK,   32'h0000_0000),
            row_op (bdeq_pkg::MODE_POP_BACK,   32'h0000_0000),
            row_cfg(5'd16)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
                set_capacity(directed_plan[i].cap);
            else
                offer_word(directed_plan[i].op, directed_plan[i].data,
                           directed_plan[i].typed, directed_plan[i].want);
        end

        // Random blocks. Each picks a capacity and an idle pattern; pushes and
        // pops come in biased runs so the queue fills, wraps and drains.
        // The queue is left as is across capacity changes.
        push_bias = 50;
        for (blk = 0; blk < 12; blk++)
        begin
            cap_val = (CAP_PLAN[blk] < 0) ? 5'($urandom_range(31)) : 5'(CAP_PLAN[blk]);
            set_capacity(cap_val);
            case (blk % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (blk == 4)
                hold_request = 1'b1;
            for (k = 0; k < BLOCK_WORDS; k++)
            begin
                if (k % 24 == 0)
                    case ($urandom_range(2))
                        0:       push_bias = 85;
                        1:       push_bias = 50;
                        default: push_bias = 15;
                    endcase
                if ($urandom_range(99) < push_bias)
                begin
                    if ($urandom_range(1) != 0)
                        op = bdeq_pkg::MODE_PUSH_BACK;
                    else
                        op = bdeq_pkg::MODE_PUSH_FRONT;
                end
                else
                begin
                    if ($urandom_range(1) != 0)
                        op = bdeq_pkg::MODE_POP_BACK;
                    else
                        op = bdeq_pkg::MODE_POP_FRONT;
                end
                offer_word(op, pick_value(), 1'b0, '0);
            end
        end

        // Drain, then wait out the settle time so the pipeline can show any stray word.
        s_axis_tvalid <= 1'b0;
        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        if (pending_results.size() != 0)
            report_mismatch("words never delivered", pending_results.size(), 32'd0);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
